### rtl/wls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wls_pkg
// shared types, codes and defaults of the windowed literal search
// ----------------------------------------------------------------------------
package wls_pkg;

   localparam int NEEDLE_BYTES_DEFAULT = 16;
   localparam int RING_DEPTH_DEFAULT   = 16;
   localparam int OFFSET_BITS_DEFAULT  = 32;

   localparam int LENGTH_BITS    = 5;
   localparam int WINDOW_BITS    = 32;
   localparam int COUNT_BITS     = 32;
   localparam int POSITION_BITS  = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // search modes
   localparam logic [2:0] MODE_FIRST    = 3'd0;
   localparam logic [2:0] MODE_NTH      = 3'd1;
   localparam logic [2:0] MODE_COUNT    = 3'd2;
   localparam logic [2:0] MODE_REPORT   = 3'd3;
   localparam logic [2:0] MODE_NTH_END  = 3'd4;

   // result status
   localparam logic [1:0] STATUS_FOUND       = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND   = 2'd1;
   localparam logic [1:0] STATUS_BEYOND_RING = 2'd2;

   // result kind
   localparam logic KIND_HIT     = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE          = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_LOW    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_HIGH   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_LENGTH = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_START  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_END    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OCCURRENCE    = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_HITS      = 3'd7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic                     result_kind;
      logic [1:0]               status;
      logic [POSITION_BITS-1:0] position;
      logic [COUNT_BITS-1:0]    match_count;
      logic                     last_result;
   } rsp_payload_type;

endpackage
`default_nettype wire

### rtl/wls_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wls stream interfaces
// valid/ready channels for buffer bytes and for results
// ----------------------------------------------------------------------------
interface wls_req_if;
   logic                     valid;
   logic                     ready;
   wls_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface wls_rsp_if;
   logic                     valid;
   logic                     ready;
   wls_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/windowed_literal_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_literal_search
// one byte per cycle while the result queue has room; a hit report or summary
// passes from the byte that causes it through the compare row, the result
// stage with the ring read and the result queue to the result port
// reset is synchronous and active high; it sets the registers to their
// defaults and clears the per-buffer state and the result queue
// ----------------------------------------------------------------------------
module windowed_literal_search #(
   parameter int NEEDLE_BYTES = wls_pkg::NEEDLE_BYTES_DEFAULT,
   parameter int RING_DEPTH   = wls_pkg::RING_DEPTH_DEFAULT,
   parameter int OFFSET_BITS  = wls_pkg::OFFSET_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   wls_req_if.sink                                    req_stream,
   wls_rsp_if.source                                  rsp_stream,
   input  wire logic                                  csr_write_enable,
   input  wire logic [wls_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [wls_pkg::CSR_DATA_BITS-1:0]     csr_write_data
);

   localparam int IDX_BITS  = (NEEDLE_BYTES > 1) ? $clog2(NEEDLE_BYTES) : 1;
   localparam int PTR_BITS  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int FILL_BITS = $clog2(RING_DEPTH + 1);
   localparam int SUM_BITS  = $clog2(2 * RING_DEPTH);
   localparam int WIDE_BITS = (OFFSET_BITS + 1 > 33) ? OFFSET_BITS + 1 : 33;
   localparam int NEEDLE_W  = NEEDLE_BYTES * 8;
   localparam int LB        = wls_pkg::LENGTH_BITS;
   localparam int WB        = wls_pkg::WINDOW_BITS;
   localparam int CNTB      = wls_pkg::COUNT_BITS;
   localparam int POSB      = wls_pkg::POSITION_BITS;
   localparam int QCB       = wls_pkg::QUEUE_CNT_BITS;

   // configuration
   logic [2:0]      mode_ff;
   logic [63:0]     needle_low_ff;
   logic [63:0]     needle_high_ff;
   logic [LB-1:0]   needle_length_ff;
   logic [WB-1:0]   window_start_ff;
   logic [WB-1:0]   window_end_ff;
   logic [CNTB-1:0] occurrence_ff;
   logic [CNTB-1:0] max_hits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= wls_pkg::MODE_FIRST;
         needle_low_ff    <= '0;
         needle_high_ff   <= '0;
         needle_length_ff <= '0;
         window_start_ff  <= '0;
         window_end_ff    <= '1;
         occurrence_ff    <= '0;
         max_hits_ff      <= '1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            wls_pkg::CSR_MODE:          mode_ff          <= csr_write_data[2:0];
            wls_pkg::CSR_NEEDLE_LOW:    needle_low_ff    <= csr_write_data;
            wls_pkg::CSR_NEEDLE_HIGH:   needle_high_ff   <= csr_write_data;
            wls_pkg::CSR_NEEDLE_LENGTH: needle_length_ff <= csr_write_data[LB-1:0];
            wls_pkg::CSR_WINDOW_START:  window_start_ff  <= csr_write_data[WB-1:0];
            wls_pkg::CSR_WINDOW_END:    window_end_ff    <= csr_write_data[WB-1:0];
            wls_pkg::CSR_OCCURRENCE:    occurrence_ff    <= csr_write_data[CNTB-1:0];
            wls_pkg::CSR_MAX_HITS:      max_hits_ff      <= csr_write_data[CNTB-1:0];
            default: begin
            end
         endcase
      end
   end

   // compare row
   logic [NEEDLE_BYTES-1:0][7:0] needle;
   logic [7:0]                   hist [NEEDLE_BYTES];
   logic [NEEDLE_BYTES-1:0]      byte_ok;
   logic [LB-1:0]                len_m1;
   logic                         accept;

   assign accept  = req_stream.valid && req_stream.ready;
   assign needle  = NEEDLE_W'({needle_high_ff, needle_low_ff});
   assign hist[0] = req_stream.payload.data_byte;
   assign len_m1  = needle_length_ff - LB'(1);
   assign byte_ok[0] = (hist[0] == needle[len_m1[IDX_BITS-1:0]]);

   for (genvar d = 1; d < NEEDLE_BYTES; d++) begin : g_cell
      wls_cell #(
         .NEEDLE_BYTES (NEEDLE_BYTES),
         .DISTANCE     (d)
      ) u_cell (
         .clock         (clock),
         .shift_en      (accept),
         .byte_in       (hist[d-1]),
         .byte_out      (hist[d]),
         .needle        (needle),
         .needle_length (needle_length_ff),
         .byte_ok       (byte_ok[d])
      );
   end

   // per-buffer state
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [LB-1:0]          suppress_ff, suppress_in;
   logic [CNTB-1:0]        hits_ff, hits_in;
   logic [POSB-1:0]        chosen_pos_ff, chosen_pos_in;
   logic                   chosen_valid_ff, chosen_valid_in;
   logic [PTR_BITS-1:0]    ptr_ff, ptr_in;
   logic [FILL_BITS-1:0]   fill_ff, fill_in;

   // result stage
   logic            s2_hit_valid_ff, s2_hit_valid_in;
   logic [POSB-1:0] s2_hit_pos_ff;
   logic [CNTB-1:0] s2_hit_count_ff;
   logic            s2_sum_valid_ff, s2_sum_valid_in;
   logic [1:0]      s2_sum_status_ff;
   logic [POSB-1:0] s2_sum_pos_ff;
   logic [CNTB-1:0] s2_sum_count_ff;
   logic            s2_sum_from_ring_ff;

   logic [2:0]           mode_eff;
   logic [WIDE_BITS-1:0] p1_w;
   logic [WIDE_BITS-1:0] start_w;
   logic                 match;
   logic [POSB-1:0]      start_pos;
   logic                 hit_report;
   logic                 ring_we;
   logic                 ring_re;
   logic [PTR_BITS-1:0]  ring_raddr;
   logic [SUM_BITS-1:0]  ring_sum;
   logic [POSB-1:0]      ring_rdata;
   logic [1:0]           sum_status;
   logic [POSB-1:0]      sum_pos;
   logic                 sum_from_ring;
   logic [CNTB-1:0]      sum_count;

   always_comb begin
      mode_eff  = (mode_ff > wls_pkg::MODE_NTH_END) ? wls_pkg::MODE_FIRST : mode_ff;
      p1_w      = WIDE_BITS'(offset_ff) + WIDE_BITS'(1);
      start_w   = p1_w - WIDE_BITS'(needle_length_ff);
      start_pos = start_w[POSB-1:0];
      match     = (needle_length_ff != '0) &&
                  (needle_length_ff <= LB'(NEEDLE_BYTES)) &&
                  (offset_ff != '1) &&
                  (p1_w >= WIDE_BITS'(needle_length_ff)) &&
                  (start_w >= WIDE_BITS'(window_start_ff)) &&
                  (p1_w <= WIDE_BITS'(window_end_ff)) &&
                  (&byte_ok);

      offset_in       = offset_ff;
      suppress_in     = suppress_ff;
      hits_in         = hits_ff;
      chosen_pos_in   = chosen_pos_ff;
      chosen_valid_in = chosen_valid_ff;
      ptr_in          = ptr_ff;
      fill_in         = fill_ff;
      hit_report      = 1'b0;
      ring_we         = 1'b0;
      ring_re         = 1'b0;
      ring_sum        = '0;
      ring_raddr      = '0;
      sum_status      = wls_pkg::STATUS_NOT_FOUND;
      sum_pos         = '0;
      sum_from_ring   = 1'b0;
      sum_count       = '0;

      if (accept) begin
         if (mode_eff == wls_pkg::MODE_NTH_END) begin
            if (match) begin
               ring_we = 1'b1;
               ptr_in  = (ptr_ff == PTR_BITS'(RING_DEPTH - 1)) ? '0 : ptr_ff + PTR_BITS'(1);
               if (fill_ff != FILL_BITS'(RING_DEPTH)) begin
                  fill_in = fill_ff + FILL_BITS'(1);
               end
               if (hits_ff != '1) begin
                  hits_in = hits_ff + CNTB'(1);
               end
            end
            suppress_in = '0;
         end else if (suppress_ff != '0) begin
            suppress_in = suppress_ff - LB'(1);
         end else if (match) begin
            suppress_in = len_m1;
            if (mode_eff == wls_pkg::MODE_REPORT) begin
               if (hits_ff < max_hits_ff) begin
                  hits_in    = hits_ff + CNTB'(1);
                  hit_report = 1'b1;
                  if (!chosen_valid_ff) begin
                     chosen_valid_in = 1'b1;
                     chosen_pos_in   = start_pos;
                  end
               end
            end else begin
               if (mode_eff == wls_pkg::MODE_NTH) begin
                  if (!chosen_valid_ff && (hits_ff == occurrence_ff)) begin
                     chosen_valid_in = 1'b1;
                     chosen_pos_in   = start_pos;
                  end
               end else if (!chosen_valid_ff) begin
                  chosen_valid_in = 1'b1;
                  chosen_pos_in   = start_pos;
               end
               if (hits_ff != '1) begin
                  hits_in = hits_ff + CNTB'(1);
               end
            end
         end

         if (offset_ff != '1) begin
            offset_in = offset_ff + OFFSET_BITS'(1);
         end

         if (req_stream.payload.last_byte) begin
            sum_count = hits_in;
            ring_sum  = SUM_BITS'(ptr_in) + SUM_BITS'(RING_DEPTH - 1) -
                        occurrence_ff[SUM_BITS-1:0];
            if (ring_sum >= SUM_BITS'(RING_DEPTH)) begin
               ring_sum = ring_sum - SUM_BITS'(RING_DEPTH);
            end
            ring_raddr = ring_sum[PTR_BITS-1:0];
            if (mode_eff == wls_pkg::MODE_NTH_END) begin
               if (occurrence_ff < hits_in) begin
                  if (occurrence_ff < CNTB'(fill_in)) begin
                     sum_status = wls_pkg::STATUS_FOUND;
                     if (match && (occurrence_ff == '0)) begin
                        sum_pos = start_pos;
                     end else begin
                        sum_from_ring = 1'b1;
                        ring_re       = 1'b1;
                     end
                  end else begin
                     sum_status = wls_pkg::STATUS_BEYOND_RING;
                  end
               end
            end else if (chosen_valid_in) begin
               sum_status = wls_pkg::STATUS_FOUND;
               sum_pos    = chosen_pos_in;
            end

            offset_in       = '0;
            suppress_in     = '0;
            hits_in         = '0;
            chosen_pos_in   = '0;
            chosen_valid_in = 1'b0;
            ptr_in          = '0;
            fill_in         = '0;
         end
      end

      s2_hit_valid_in = accept && hit_report;
      s2_sum_valid_in = accept && req_stream.payload.last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff       <= '0;
         suppress_ff     <= '0;
         hits_ff         <= '0;
         chosen_pos_ff   <= '0;
         chosen_valid_ff <= 1'b0;
         ptr_ff          <= '0;
         fill_ff         <= '0;
         s2_hit_valid_ff <= 1'b0;
         s2_sum_valid_ff <= 1'b0;
      end else begin
         offset_ff       <= offset_in;
         suppress_ff     <= suppress_in;
         hits_ff         <= hits_in;
         chosen_pos_ff   <= chosen_pos_in;
         chosen_valid_ff <= chosen_valid_in;
         ptr_ff          <= ptr_in;
         fill_ff         <= fill_in;
         s2_hit_valid_ff <= s2_hit_valid_in;
         s2_sum_valid_ff <= s2_sum_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_hit_valid_in) begin
         s2_hit_pos_ff   <= start_pos;
         s2_hit_count_ff <= hits_ff + CNTB'(1);
      end
      if (s2_sum_valid_in) begin
         s2_sum_status_ff    <= sum_status;
         s2_sum_pos_ff       <= sum_pos;
         s2_sum_count_ff     <= sum_count;
         s2_sum_from_ring_ff <= sum_from_ring;
      end
   end

   wls_ring #(
      .RING_DEPTH (RING_DEPTH),
      .PTR_BITS   (PTR_BITS)
   ) u_ring (
      .clock      (clock),
      .write_en   (ring_we),
      .write_addr (ptr_ff),
      .write_data (start_pos),
      .read_en    (ring_re),
      .read_addr  (ring_raddr),
      .read_data  (ring_rdata)
   );

   // results into the queue
   wls_pkg::rsp_payload_type hit_result;
   wls_pkg::rsp_payload_type sum_result;
   wls_pkg::rsp_payload_type push_first;
   logic [1:0]               push_count;
   logic [QCB-1:0]           queue_level;
   logic [QCB:0]             queue_demand;

   always_comb begin
      hit_result.result_kind = wls_pkg::KIND_HIT;
      hit_result.status      = wls_pkg::STATUS_FOUND;
      hit_result.position    = s2_hit_pos_ff;
      hit_result.match_count = s2_hit_count_ff;
      hit_result.last_result = 1'b0;

      sum_result.result_kind = wls_pkg::KIND_SUMMARY;
      sum_result.status      = s2_sum_status_ff;
      sum_result.position    = s2_sum_from_ring_ff ? ring_rdata : s2_sum_pos_ff;
      sum_result.match_count = s2_sum_count_ff;
      sum_result.last_result = 1'b1;

      push_first = s2_hit_valid_ff ? hit_result : sum_result;
      push_count = 2'(s2_hit_valid_ff) + 2'(s2_sum_valid_ff);
   end

   wls_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_first  (push_first),
      .push_second (sum_result),
      .out_valid   (rsp_stream.valid),
      .out_ready   (rsp_stream.ready),
      .out_payload (rsp_stream.payload),
      .level       (queue_level)
   );

   // room for the results still in the result stage plus two more
   assign queue_demand     = (QCB + 1)'(queue_level) + (QCB + 1)'(push_count);
   assign req_stream.ready = (queue_demand <= (QCB + 1)'(wls_pkg::QUEUE_DEPTH - 2));

endmodule
`default_nettype wire

### rtl/wls_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wls_cell
// one history byte of the search row: holds the byte seen DISTANCE transfers
// back, passes it on, and compares it with the needle byte it lines up with
// ----------------------------------------------------------------------------
module wls_cell #(
   parameter int NEEDLE_BYTES = wls_pkg::NEEDLE_BYTES_DEFAULT,
   parameter int DISTANCE     = 1
) (
   input  wire logic                                clock,
   input  wire logic                                shift_en,
   input  wire logic [7:0]                          byte_in,
   output logic      [7:0]                          byte_out,
   input  wire logic [NEEDLE_BYTES-1:0][7:0]        needle,
   input  wire logic [wls_pkg::LENGTH_BITS-1:0]     needle_length,
   output logic                                     byte_ok
);

   localparam int IDX_BITS = (NEEDLE_BYTES > 1) ? $clog2(NEEDLE_BYTES) : 1;
   localparam logic [wls_pkg::LENGTH_BITS-1:0] DIST = wls_pkg::LENGTH_BITS'(DISTANCE);

   logic [7:0]                      byte_ff;
   logic [wls_pkg::LENGTH_BITS-1:0] needle_idx;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out   = byte_ff;
   assign needle_idx = needle_length - DIST - wls_pkg::LENGTH_BITS'(1);
   assign byte_ok    = (needle_length <= DIST) ||
                       (byte_ff == needle[needle_idx[IDX_BITS-1:0]]);

endmodule
`default_nettype wire

### rtl/wls_ring.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wls_ring
// ring of recent hit start offsets, one write and one registered read port
// ----------------------------------------------------------------------------
module wls_ring #(
   parameter int RING_DEPTH = wls_pkg::RING_DEPTH_DEFAULT,
   parameter int PTR_BITS   = 4
) (
   input  wire logic                                clock,
   input  wire logic                                write_en,
   input  wire logic [PTR_BITS-1:0]                 write_addr,
   input  wire logic [wls_pkg::POSITION_BITS-1:0]   write_data,
   input  wire logic                                read_en,
   input  wire logic [PTR_BITS-1:0]                 read_addr,
   output logic      [wls_pkg::POSITION_BITS-1:0]   read_data
);

   logic [wls_pkg::POSITION_BITS-1:0] mem [RING_DEPTH];
   logic [wls_pkg::POSITION_BITS-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[write_addr] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (read_en) begin
         read_data_ff <= mem[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule
`default_nettype wire

### rtl/wls_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wls_queue
// result queue, takes up to two results per cycle and hands out one while the receiver is ready
// ----------------------------------------------------------------------------
module wls_queue (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [1:0]                            push_count,
   input  wire wls_pkg::rsp_payload_type              push_first,
   input  wire wls_pkg::rsp_payload_type              push_second,
   output logic                                       out_valid,
   input  wire logic                                  out_ready,
   output wls_pkg::rsp_payload_type                   out_payload,
   output logic [wls_pkg::QUEUE_CNT_BITS-1:0]         level
);

   localparam int PB = wls_pkg::QUEUE_PTR_BITS;
   localparam int CB = wls_pkg::QUEUE_CNT_BITS;

   wls_pkg::rsp_payload_type entry_ff [wls_pkg::QUEUE_DEPTH];
   logic [PB-1:0] head_ff, head_in;
   logic [PB-1:0] tail_ff, tail_in;
   logic [CB-1:0] count_ff, count_in;
   logic          pop;

   assign out_valid   = (count_ff != '0);
   assign out_payload = entry_ff[head_ff];
   assign level       = count_ff;
   assign pop         = out_valid && out_ready;

   always_comb begin
      head_in  = pop ? head_ff + PB'(1) : head_ff;
      tail_in  = tail_ff + PB'(push_count);
      count_in = count_ff + CB'(push_count) - CB'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[tail_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         entry_ff[tail_ff + PB'(1)] <= push_second;
      end
   end

endmodule
`default_nettype wire

### rtl/wls_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wls_checker
// port-level checks on the result channel of the windowed literal search
// ----------------------------------------------------------------------------
module wls_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire wls_pkg::rsp_payload_type rsp_payload
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // nothing pending right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // only the summary closes a buffer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.result_kind == rsp_payload.last_result))
      else $error("result kind and last flag disagree");

   // no position without a hit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != wls_pkg::STATUS_FOUND) |->
         (rsp_payload.position == '0))
      else $error("position set on a miss");

   // a hit report always counts itself
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.result_kind == wls_pkg::KIND_HIT) |->
         (rsp_payload.status == wls_pkg::STATUS_FOUND) &&
         (rsp_payload.match_count != '0))
      else $error("hit report without a counted hit");

endmodule

bind windowed_literal_search wls_checker u_wls_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_stream.valid),
   .rsp_ready   (rsp_stream.ready),
   .rsp_payload (rsp_stream.payload)
);
`default_nettype wire

### bench/wls_search_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wls_search_checker
// watches the byte channel, the result channel and the register port,
// predicts the hit reports and the summary of every buffer from its own copy
// of the registers and the search state, and checks each result transfer
// field by field against the oldest prediction
// ----------------------------------------------------------------------------
module wls_search_checker
   import wls_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   wls_req_if                             req_stream,
   wls_rsp_if                             rsp_stream,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data,
   output int unsigned                    failures,
   output int unsigned                    results_owed
);

   localparam int HISTORY = NEEDLE_BYTES_DEFAULT - 1;
   localparam int RING    = RING_DEPTH_DEFAULT;

   logic [2:0]   mode_reg;
   logic [127:0] needle_reg;
   logic [4:0]   length_reg;
   logic [31:0]  window_start_reg;
   logic [31:0]  window_end_reg;
   logic [31:0]  occurrence_reg;
   logic [31:0]  max_hits_reg;

   logic [7:0]   history [HISTORY];
   logic [31:0]  offset;
   int           suppress;
   logic [31:0]  hit_total;
   logic [31:0]  chosen_pos;
   bit           chosen_ok;
   logic [31:0]  recent [RING];
   int           ring_ptr;
   int           ring_fill;

   rsp_payload_type expected_results [$];

   function automatic void clear_buffer();
      int j;
      for (j = 0; j < HISTORY; j++) history[j] = 8'h00;
      offset     = '0;
      suppress   = 0;
      hit_total  = '0;
      chosen_pos = '0;
      chosen_ok  = 1'b0;
      ring_ptr   = 0;
      ring_fill  = 0;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_payload_type got;
      rsp_payload_type want;
      req_payload_type item;
      rsp_payload_type r;
      logic [2:0]  m;
      logic [32:0] len_wide;
      logic [32:0] end_excl;
      logic [32:0] hit_start;
      logic [7:0]  back;
      logic        hit;
      int          len;
      int          j;
      int          d;

      if (reset) begin
         mode_reg         = MODE_FIRST;
         needle_reg       = '0;
         length_reg       = '0;
         window_start_reg = '0;
         window_end_reg   = '1;
         occurrence_reg   = '0;
         max_hits_reg     = '1;
         clear_buffer();
         expected_results.delete();
      end else begin
         // result side
         if (rsp_stream.valid && rsp_stream.ready) begin
            got = rsp_stream.payload;
            if (expected_results.size() == 0) begin
               $error("result transfer with nothing expected: kind %0d status %0d pos %0d",
                      got.result_kind, got.status, got.position);
               failures++;
            end else begin
               want = expected_results.pop_front();
               check_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
               check_field("status", 32'(want.status), 32'(got.status));
               check_field("position", want.position, got.position);
               check_field("match_count", want.match_count, got.match_count);
               check_field("last_result", 32'(want.last_result), 32'(got.last_result));
            end
         end

         // byte side
         if (req_stream.valid && req_stream.ready) begin
            item      = req_stream.payload;
            m         = (mode_reg > MODE_NTH_END) ? MODE_FIRST : mode_reg;
            len       = int'(length_reg);
            len_wide  = {28'b0, length_reg};
            end_excl  = {1'b0, offset} + 33'd1;
            hit_start = end_excl - len_wide;
            hit       = 1'b0;
            if (len >= 1 && len <= NEEDLE_BYTES_DEFAULT && offset != '1 &&
                end_excl >= len_wide && hit_start >= {1'b0, window_start_reg} &&
                end_excl <= {1'b0, window_end_reg}) begin
               hit = 1'b1;
               for (j = 0; j < len; j++) begin
                  d    = len - 1 - j;
                  back = (d == 0) ? item.data_byte : history[d - 1];
                  if (back != needle_reg[j*8 +: 8]) hit = 1'b0;
               end
            end

            if (m == MODE_NTH_END) begin
               // every hit counts, overlaps included
               if (hit) begin
                  recent[ring_ptr] = hit_start[31:0];
                  ring_ptr = (ring_ptr + 1) % RING;
                  if (ring_fill < RING) ring_fill++;
                  if (hit_total != '1) hit_total++;
               end
               suppress = 0;
            end else if (suppress > 0) begin
               suppress--;
            end else if (hit) begin
               suppress = len - 1;
               if (m == MODE_REPORT) begin
                  if (hit_total < max_hits_reg) begin
                     hit_total++;
                     if (!chosen_ok) begin
                        chosen_ok  = 1'b1;
                        chosen_pos = hit_start[31:0];
                     end
                     r.result_kind = KIND_HIT;
                     r.status      = STATUS_FOUND;
                     r.position    = hit_start[31:0];
                     r.match_count = hit_total;
                     r.last_result = 1'b0;
                     expected_results.push_back(r);
                  end
               end else begin
                  if (m == MODE_NTH) begin
                     if (!chosen_ok && hit_total == occurrence_reg) begin
                        chosen_ok  = 1'b1;
                        chosen_pos = hit_start[31:0];
                     end
                  end else if (!chosen_ok) begin
                     chosen_ok  = 1'b1;
                     chosen_pos = hit_start[31:0];
                  end
                  if (hit_total != '1) hit_total++;
               end
            end

            for (j = HISTORY - 1; j > 0; j--) history[j] = history[j - 1];
            history[0] = item.data_byte;
            if (offset != '1) offset++;

            if (item.last_byte) begin
               r.result_kind = KIND_SUMMARY;
               r.status      = STATUS_NOT_FOUND;
               r.position    = '0;
               r.match_count = hit_total;
               r.last_result = 1'b1;
               if (m == MODE_NTH_END) begin
                  if (occurrence_reg < hit_total) begin
                     if (occurrence_reg < 32'(ring_fill)) begin
                        r.status   = STATUS_FOUND;
                        r.position = recent[(ring_ptr + RING - 1 - int'(occurrence_reg)) % RING];
                     end else begin
                        r.status = STATUS_BEYOND_RING;
                     end
                  end
               end else if (chosen_ok) begin
                  r.status   = STATUS_FOUND;
                  r.position = chosen_pos;
               end
               expected_results.push_back(r);
               clear_buffer();
            end
         end

         // register port
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MODE:          mode_reg           = csr_write_data[2:0];
               CSR_NEEDLE_LOW:    needle_reg[63:0]   = csr_write_data;
               CSR_NEEDLE_HIGH:   needle_reg[127:64] = csr_write_data;
               CSR_NEEDLE_LENGTH: length_reg         = csr_write_data[4:0];
               CSR_WINDOW_START:  window_start_reg   = csr_write_data[31:0];
               CSR_WINDOW_END:    window_end_reg     = csr_write_data[31:0];
               CSR_OCCURRENCE:    occurrence_reg     = csr_write_data[31:0];
               CSR_MAX_HITS:      max_hits_reg       = csr_write_data[31:0];
               default: ;
            endcase
         end
      end
      results_owed = expected_results.size();
   end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives the windowed literal search with directed buffers, a back-pressure
// burst and random buffers under random register settings and idle patterns;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;
   import wls_pkg::*;

   localparam int HALF_PERIOD = 5;
   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEMS_PER_PHASE = 150;

   logic clock;
   logic reset;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   int unsigned failures;
   int unsigned results_owed;
   int unsigned cycle_count = 0;
   int unsigned hold_span = 0;
   logic        hold_off = 1'b0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;

   logic [127:0] needle_now;
   logic [4:0]   length_now;

   wls_req_if req_if ();
   wls_rsp_if rsp_if ();

   windowed_literal_search i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_stream       (req_if),
      .rsp_stream       (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   wls_search_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_stream       (req_if),
      .rsp_stream       (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .failures         (failures),
      .results_owed     (results_owed)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
   end

   // long receiver hold-off
   always begin
      wait (hold_span != 0);
      hold_off = 1'b1;
      repeat (hold_span) @(posedge clock);
      hold_off  = 1'b0;
      hold_span = 0;
   end

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // returns at the rising edge of the transfer
   task automatic send_byte(input logic [7:0] data, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid   <= 1'b0;
         req_if.payload <= 9'($urandom);
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= {data, last};
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_text(input string text);
      int k;
      for (k = 0; k < text.len(); k++) send_byte(text[k], k == text.len() - 1);
   endtask

   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      wait (results_owed == 0);
      repeat (6) @(negedge clock);
   endtask

   initial begin
      logic [7:0] body [$];
      logic [2:0] mode_now;
      int phase;
      int sent;
      int reps;
      int roll;
      int n;
      int k;
      int cut;
      int pick;

      clock            = 1'b0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.payload   = '0;
      rsp_if.ready     = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults: empty needle never matches
      send_byte(8'h00, 1'b1);
      settle();

      // report all with a limit, hits without overlap
      write_reg(CSR_MODE, 64'(MODE_REPORT));
      write_reg(CSR_NEEDLE_LOW, 64'h6161);
      write_reg(CSR_NEEDLE_LENGTH, 64'd2);
      write_reg(CSR_MAX_HITS, 64'd2);
      send_text("aaaaaa");
      settle();

      // nth from end counts overlapping hits
      write_reg(CSR_MODE, 64'(MODE_NTH_END));
      write_reg(CSR_OCCURRENCE, 64'd1);
      send_text("aaa");
      settle();

      // full-length needle of all ones
      write_reg(CSR_MODE, 64'(MODE_FIRST));
      write_reg(CSR_NEEDLE_LOW, '1);
      write_reg(CSR_NEEDLE_HIGH, '1);
      write_reg(CSR_NEEDLE_LENGTH, 64'd16);
      write_reg(CSR_MAX_HITS, 64'hFFFF_FFFF);
      for (k = 0; k < 16; k++) send_byte(8'hFF, k == 15);
      settle();

      // receiver holds off while every byte is a hit report
      write_reg(CSR_MODE, 64'(MODE_REPORT));
      write_reg(CSR_NEEDLE_LOW, 64'h61);
      write_reg(CSR_NEEDLE_LENGTH, 64'd1);
      hold_span = 150;
      for (k = 0; k < 40; k++) send_byte(8'h61, k == 39);
      settle();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 79; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 79; end
            default: begin send_idle_pct = 29; stall_pct = 29; end
         endcase
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            settle();

            roll = $urandom_range(99);
            mode_now = (roll < 88) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
            write_reg(CSR_MODE, {61'b0, mode_now});

            roll = $urandom_range(9);
            for (k = 0; k < 16; k++) begin
               case (roll)
                  0: needle_now[k*8 +: 8] = 8'hFF;
                  1: needle_now[k*8 +: 8] = 8'h00;
                  default: needle_now[k*8 +: 8] = ($urandom_range(1) == 1) ?
                     8'(8'h61 + 8'($urandom_range(2))) : 8'($urandom_range(255));
               endcase
            end
            write_reg(CSR_NEEDLE_LOW, needle_now[63:0]);
            write_reg(CSR_NEEDLE_HIGH, needle_now[127:64]);

            roll = $urandom_range(99);
            if (roll < 6) length_now = 5'd0;
            else if (roll < 12) length_now = 5'($urandom_range(31, 17));
            else if (roll < 22) length_now = 5'd16;
            else if (roll < 60) length_now = 5'($urandom_range(6, 1));
            else length_now = 5'($urandom_range(16, 1));
            write_reg(CSR_NEEDLE_LENGTH, {59'b0, length_now});

            roll = $urandom_range(99);
            if (roll < 60) write_reg(CSR_WINDOW_START, 64'd0);
            else if (roll < 88) write_reg(CSR_WINDOW_START, 64'($urandom_range(12)));
            else if (roll < 94) write_reg(CSR_WINDOW_START, 64'hFFFF_FFFF);
            else write_reg(CSR_WINDOW_START, 64'($urandom));

            roll = $urandom_range(99);
            if (roll < 50) write_reg(CSR_WINDOW_END, 64'hFFFF_FFFF);
            else if (roll < 88) write_reg(CSR_WINDOW_END, 64'($urandom_range(48, 4)));
            else if (roll < 94) write_reg(CSR_WINDOW_END, 64'd0);
            else write_reg(CSR_WINDOW_END, 64'($urandom));

            roll = $urandom_range(99);
            if (roll < 10) write_reg(CSR_OCCURRENCE, 64'd0);
            else if (roll < 18) write_reg(CSR_OCCURRENCE, 64'hFFFF_FFFF);
            else if (roll < 26) write_reg(CSR_OCCURRENCE, 64'($urandom));
            else write_reg(CSR_OCCURRENCE, 64'($urandom_range(24)));

            roll = $urandom_range(99);
            if (roll < 40) write_reg(CSR_MAX_HITS, 64'hFFFF_FFFF);
            else if (roll < 92) write_reg(CSR_MAX_HITS, 64'($urandom_range(4)));
            else write_reg(CSR_MAX_HITS, 64'd0);

            reps = $urandom_range(3, 1);
            repeat (reps) begin
               body.delete();
               n = ($urandom_range(9) == 0) ? $urandom_range(60, 30) : $urandom_range(20, 1);
               while (body.size() < n) begin
                  roll = $urandom_range(99);
                  if (roll < 20) begin
                     // whole needle mostly, sometimes cut short
                     cut = (length_now > 5'd16) ? 16 : int'(length_now);
                     if (roll >= 15) cut = $urandom_range(cut);
                     for (k = 0; k < cut; k++) body.push_back(needle_now[k*8 +: 8]);
                  end else if (roll < 70) begin
                     pick = $urandom_range(15);
                     body.push_back(needle_now[pick*8 +: 8]);
                  end else begin
                     body.push_back(8'($urandom_range(255)));
                  end
               end
               for (k = 0; k < body.size(); k++) send_byte(body[k], k == body.size() - 1);
               sent += body.size();
            end
         end
      end

      settle();
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
